// ----- rtl/core/crc16_frame_encoder_top_assert.svh -----
// assertion macros used by the frame encoder checker
`ifndef CRC16_FRAME_ENCODER_TOP_ASSERT_SVH
`define CRC16_FRAME_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/crc16f_pkg.sv -----
package crc16f_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] MAGIC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic REG_MAGIC_FIRST  = 1'b0;
  localparam logic REG_MAGIC_SECOND = 1'b1;

  // one classified payload byte, handed from front to back
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [15:0] len;
    logic [15:0] crc;
  } crc16f_desc_t;

  typedef enum logic [2:0] {
    PH_MAGIC1,
    PH_MAGIC2,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } crc16f_phase_t;

  // msb-first crc-16, one byte folded in
  function automatic logic [15:0] crc16f_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/crc16f_front.sv -----
module crc16f_front
  import crc16f_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_payload_byte,
  input  logic [15:0]  in_frame_length,
  output logic         push_valid,
  input  logic         push_ready,
  output crc16f_desc_t push_desc
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] left_r, left_nxt;
  logic        in_frame_r, in_frame_nxt;

  logic        accept;
  logic        first;
  logic [15:0] eff_len;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic        last;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    first    = !in_frame_r;
    // a zero length is taken as a one-byte frame
    eff_len  = (in_frame_length == 16'd0) ? 16'd1 : in_frame_length;
    crc_base = first ? CRC_INIT : crc_r;
    if (first) begin
      left_nxt = eff_len - 16'd1;
    end else if (left_r != 16'd0) begin
      left_nxt = left_r - 16'd1;
    end else begin
      left_nxt = 16'd0;
    end
    crc_new      = crc16f_fold(crc_base, in_payload_byte);
    last         = (left_nxt == 16'd0);
    crc_nxt      = last ? CRC_INIT : crc_new;
    in_frame_nxt = !last;

    push_desc.first = first;
    push_desc.last  = last;
    push_desc.data  = in_payload_byte;
    push_desc.len   = in_frame_length;
    push_desc.crc   = crc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      left_r     <= 16'd0;
      in_frame_r <= 1'b0;
    end else if (accept) begin
      crc_r      <= crc_nxt;
      left_r     <= left_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ----- rtl/core/crc16f_queue.sv -----
module crc16f_queue
  import crc16f_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  crc16f_desc_t push_desc,
  output logic         pop_valid,
  input  logic         pop_ready,
  output crc16f_desc_t pop_desc
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  crc16f_desc_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- rtl/core/crc16f_back.sv -----
module crc16f_back
  import crc16f_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  crc16f_desc_t pop_desc,
  input  logic [7:0]   magic_first,
  input  logic [7:0]   magic_second,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_run_last,
  output logic         out_frame_end
);

  crc16f_phase_t phase_r, phase_nxt;
  crc16f_phase_t cur_ph, step_ph;

  logic       out_valid_r;
  logic [7:0] out_byte_r, byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic       frame_end_r, frame_end_nxt;
  logic       load;

  assign load = pop_valid && (!out_valid_r || out_ready);

  always_comb begin
    // a byte inside a frame skips the header
    cur_ph = (phase_r == PH_MAGIC1 && !pop_desc.first) ? PH_DATA : phase_r;
    frame_end_nxt = 1'b0;
    run_last_nxt  = 1'b0;
    unique case (cur_ph)
      PH_MAGIC1: begin
        byte_nxt = magic_first;
        step_ph  = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        byte_nxt = magic_second;
        step_ph  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        byte_nxt = pop_desc.len[7:0];
        step_ph  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        byte_nxt = pop_desc.len[15:8];
        step_ph  = PH_DATA;
      end
      PH_DATA: begin
        byte_nxt     = pop_desc.data;
        run_last_nxt = !pop_desc.last;
        step_ph      = pop_desc.last ? PH_CRC_LO : PH_MAGIC1;
      end
      PH_CRC_LO: begin
        byte_nxt = pop_desc.crc[7:0];
        step_ph  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_nxt      = pop_desc.crc[15:8];
        run_last_nxt  = 1'b1;
        frame_end_nxt = 1'b1;
        step_ph       = PH_MAGIC1;
      end
      default: begin
        byte_nxt = pop_desc.data;
        step_ph  = PH_MAGIC1;
      end
    endcase
    phase_nxt = load ? step_ph : phase_r;
    pop_ready = load && run_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= byte_nxt;
      run_last_r  <= run_last_nxt;
      frame_end_r <= frame_end_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

// ----- rtl/core/crc16_frame_encoder_top.sv -----
// CRC-16 frame encoder. Takes one payload byte per transfer on the in_ channel
// (the length is sampled with a frame's first byte) and sends the framed stream
// one byte per transfer on the out_ channel: two sync bytes, length low/high,
// the payload bytes, then CRC-16 low/high (poly 0x1021, init 0xFFFF, msb first).
// The front stage computes the CRC and classifies each byte in the cycle it is
// taken, so input transfers can follow back to back while the queue has room;
// the back stage sends one byte per cycle through its output register while
// out_ready is high. A first byte goes out after the sync and length bytes, a
// last byte before the CRC bytes, and the QDEPTH-entry queue absorbs header
// and trailer bursts. The sync bytes are registers at byte addresses 0 and 4.
module crc16_frame_encoder_top
  import crc16f_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_payload_byte,
  input  logic [15:0]       in_frame_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_frame_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [7:0]   magic_first_r, magic_second_r;
  logic         cfg_wr;
  logic         cfg_sel;
  logic         push_valid, push_ready;
  logic         pop_valid, pop_ready;
  crc16f_desc_t push_desc, pop_desc;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_MAGIC_FIRST) magic_first_r <= pwdata[7:0];
      else magic_second_r <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MAGIC_FIRST:  prdata = {{(CFG_DW - 8){1'b0}}, magic_first_r};
      REG_MAGIC_SECOND: prdata = {{(CFG_DW - 8){1'b0}}, magic_second_r};
      default:          prdata = '0;
    endcase
  end

  crc16f_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_frame_length (in_frame_length),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_desc       (push_desc)
  );

  crc16f_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  crc16f_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_desc      (pop_desc),
    .magic_first   (magic_first_r),
    .magic_second  (magic_second_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- rtl/core/crc16f_checker.sv -----
`include "crc16_frame_encoder_top_assert.svh"

module crc16f_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);

  // input transfers whose last result has not yet gone out
  logic [7:0] pending_r, pending_nxt;
  logic       in_xfer, out_done;

  assign in_xfer  = in_valid && in_ready;
  assign out_done = out_valid && out_ready && out_run_last;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_done) pending_nxt = pending_r + 8'd1;
    else if (out_done && !in_xfer) pending_nxt = pending_r - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `CFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_run_last) && $stable(out_frame_end), "stalled result changed")
  `CFE_ASSERT_NOW(a_end_is_last, out_valid && out_frame_end, out_run_last, "frame end without run last")
  `CFE_ASSERT_NOW(a_no_orphan, out_valid, pending_r != 8'd0, "result with no pending input")
  `CFE_ASSERT_NOW(a_idle_ready, pending_r == 8'd0, in_ready, "idle block not ready")

endmodule

bind crc16_frame_encoder_top crc16f_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end)
);
